// ===== src/rra_pkg.sv =====
// ----------------------------------------------------------------------------
// rra_pkg
// Shared types and constants for the randomized region address block.
// ----------------------------------------------------------------------------
`default_nettype none

package rra_pkg;

  // region codes; codes 6 and 7 are unknown regions
  typedef enum logic [2:0] {
    REGION_STACK = 3'd0,
    REGION_HEAP  = 3'd1,
    REGION_MMAP  = 3'd2,
    REGION_EXEC  = 3'd3,
    REGION_LIB   = 3'd4,
    REGION_VDSO  = 3'd5
  } region_t;

  // operation codes carried in tuser
  localparam logic OP_RANDOMIZE = 1'b0;
  localparam logic OP_SEED      = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_ENTROPY = 2'd1;
  localparam logic [1:0] CFG_MASK    = 2'd2;

  localparam logic [4:0] ENTROPY_LIMIT = 5'd24;

  // page limits per region
  localparam logic [15:0] PAGES_STD  = 16'h0FFF;
  localparam logic [15:0] PAGES_MMAP = 16'hFFFF;
  localparam logic [15:0] PAGES_EXEC = 16'h007F;
  localparam logic [15:0] PAGES_VDSO = 16'h003F;

  // xorshift shift amounts
  localparam int unsigned SHIFT_A = 13;
  localparam int unsigned SHIFT_B = 7;
  localparam int unsigned SHIFT_C = 17;

  // generator control from the input stage
  typedef struct packed {
    logic load;
    logic advance;
  } gen_ctrl_t;

endpackage : rra_pkg

`default_nettype wire

// ===== src/rra_gen.sv =====
// ----------------------------------------------------------------------------
// rra_gen
// 64-bit xorshift generator state with seed load and single-step advance.
// ----------------------------------------------------------------------------
`default_nettype none

module rra_gen
  import rra_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire gen_ctrl_t   ctrl,
  input  wire logic [63:0] seed,
  output logic      [31:0] rnd
);

  logic [63:0] state;
  logic [63:0] state_next;
  logic [63:0] x1;
  logic [63:0] x2;
  logic [63:0] x3;

  always_comb begin
    x1 = state ^ (state << SHIFT_A);
    x2 = x1 ^ (x1 >> SHIFT_B);
    x3 = x2 ^ (x2 << SHIFT_C);
  end

  // high half of the stepped state, valid for the transfer that advances it
  assign rnd = x3[63:32];

  always_comb begin
    state_next = state;
    if (ctrl.load) begin
      state_next = seed;
    end else if (ctrl.advance) begin
      state_next = x3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else begin
      state <= state_next;
    end
  end

endmodule : rra_gen

`default_nettype wire

// ===== src/randomized_region_address.sv =====
// ----------------------------------------------------------------------------
// randomized_region_address
// Randomizes a base address by a page-aligned xorshift offset per region.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             content
//  s_axis   in   tvalid/tready         tuser: operation, region; tdata: base, seed
//  m_axis   out  tvalid/tready         tdata: address, offset_bytes, random_value
//  cfg      in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
//  one transfer per cycle in and out while the output is not stalled; three register
//  stages in order: generator step, page reduction, scale and add
//  the generator steps in the input transfer cycle, so items chain back to back
//  a stalled output holds its result while the two inner stages keep filling
//  synchronous reset clears configuration, valid flags and generator state
// ----------------------------------------------------------------------------
`default_nettype none

module randomized_region_address
  import rra_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,  // base_address[31:0], seed_value[95:32]
  input  wire logic [3:0]  s_axis_tuser,  // operation[0], region[3:1]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [95:0] m_axis_tdata,  // address[31:0], offset_bytes[59:32],
                                          // random_value[91:60], zero[95:92]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [5:0]  cfg_data
);

  localparam logic [16:0] PageBytes = 17'(PAGE_BYTES);

  function automatic logic [15:0] mod_4095(input logic [23:0] v);
    logic [12:0] s;
    s = {1'b0, v[11:0]} + {1'b0, v[23:12]};
    if (s >= 13'(PAGES_STD)) s = s - 13'(PAGES_STD);
    if (s >= 13'(PAGES_STD)) s = s - 13'(PAGES_STD);
    return {4'b0, s[11:0]};
  endfunction

  function automatic logic [15:0] mod_65535(input logic [23:0] v);
    logic [16:0] s;
    s = {1'b0, v[15:0]} + {9'b0, v[23:16]};
    if (s >= 17'(PAGES_MMAP)) s = s - 17'(PAGES_MMAP);
    return s[15:0];
  endfunction

  function automatic logic [15:0] mod_127(input logic [23:0] v);
    logic [8:0] s1;
    logic [7:0] s2;
    s1 = {2'b0, v[6:0]} + {2'b0, v[13:7]} + {2'b0, v[20:14]} + {6'b0, v[23:21]};
    s2 = {1'b0, s1[6:0]} + {6'b0, s1[8:7]};
    if (s2 >= 8'(PAGES_EXEC)) s2 = s2 - 8'(PAGES_EXEC);
    return {9'b0, s2[6:0]};
  endfunction

  function automatic logic [15:0] mod_63(input logic [23:0] v);
    logic [7:0] s1;
    logic [6:0] s2;
    s1 = {2'b0, v[5:0]} + {2'b0, v[11:6]} + {2'b0, v[17:12]} + {2'b0, v[23:18]};
    s2 = {1'b0, s1[5:0]} + {5'b0, s1[7:6]};
    if (s2 >= 7'(PAGES_VDSO)) s2 = s2 - 7'(PAGES_VDSO);
    return {10'b0, s2[5:0]};
  endfunction

  // configuration
  logic       enable;
  logic [4:0] entropy_width;
  logic [5:0] region_mask;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      entropy_width <= '0;
      region_mask   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENABLE:  enable        <= cfg_data[0];
        CFG_ENTROPY: entropy_width <= cfg_data[4:0];
        CFG_MASK:    region_mask   <= cfg_data;
        default:     ;
      endcase
    end
  end

  // input decode
  logic        in_fire;
  logic        in_op;
  region_t     in_region;
  logic [31:0] in_base;
  logic [63:0] in_seed;
  logic        in_known;
  logic        in_hit;
  logic        in_active;
  logic        in_step;
  logic        in_apply;
  gen_ctrl_t   gen_ctrl;
  logic [31:0] gen_rnd;

  assign in_op     = s_axis_tuser[0];
  assign in_region = region_t'(s_axis_tuser[3:1]);
  assign in_base   = s_axis_tdata[31:0];
  assign in_seed   = s_axis_tdata[95:32];

  always_comb begin
    unique case (in_region)
      REGION_STACK: begin in_known = 1'b1; in_hit = region_mask[0]; end
      REGION_HEAP:  begin in_known = 1'b1; in_hit = region_mask[1]; end
      REGION_MMAP:  begin in_known = 1'b1; in_hit = region_mask[2]; end
      REGION_EXEC:  begin in_known = 1'b1; in_hit = region_mask[3]; end
      REGION_LIB:   begin in_known = 1'b1; in_hit = region_mask[4]; end
      REGION_VDSO:  begin in_known = 1'b1; in_hit = region_mask[5]; end
      default:      begin in_known = 1'b0; in_hit = 1'b0; end
    endcase
  end

  assign in_active = enable && (in_base != '0) && (in_op == OP_RANDOMIZE);
  // unknown regions still step the generator
  assign in_step   = in_active && (!in_known || in_hit);
  assign in_apply  = in_active && in_known && in_hit;

  assign gen_ctrl.load    = in_fire && (in_op == OP_SEED);
  assign gen_ctrl.advance = in_fire && in_step;

  rra_gen u_gen (
    .clk  (clk),
    .rst  (rst),
    .ctrl (gen_ctrl),
    .seed (in_seed),
    .rnd  (gen_rnd)
  );

  // pipeline stages and ready chain
  logic        a_valid;
  logic        a_apply;
  region_t     a_region;
  logic [31:0] a_base;
  logic [31:0] a_rnd;

  logic        b_valid;
  logic        b_apply;
  logic        b_stack;
  logic [15:0] b_pages;
  logic [31:0] b_base;
  logic [31:0] b_rnd;

  logic        o_valid;
  logic [31:0] o_address;
  logic [27:0] o_offset;
  logic [31:0] o_rnd;

  logic rdy_o;
  logic rdy_b;
  logic rdy_a;

  assign rdy_o = !o_valid || m_axis_tready;
  assign rdy_b = !b_valid || rdy_o;
  assign rdy_a = !a_valid || rdy_b;

  assign s_axis_tready = rdy_a;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (rdy_a) begin
      a_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_apply  <= in_apply;
      a_region <= in_region;
      a_base   <= (in_op == OP_SEED) ? '0 : in_base;
      a_rnd    <= in_step ? gen_rnd : '0;
    end
  end

  // page reduction
  logic [4:0]  bits;
  logic [23:0] emask;
  logic [23:0] masked;
  logic [15:0] pages;

  assign bits   = (entropy_width > ENTROPY_LIMIT) ? ENTROPY_LIMIT : entropy_width;
  assign emask  = ~(24'hFF_FFFF << bits);
  assign masked = a_rnd[23:0] & emask;

  always_comb begin
    unique case (a_region)
      REGION_STACK, REGION_HEAP, REGION_LIB: pages = mod_4095(masked);
      REGION_MMAP:                           pages = mod_65535(masked);
      REGION_EXEC:                           pages = mod_127(masked);
      REGION_VDSO:                           pages = mod_63(masked);
      default:                               pages = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (rdy_b) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && rdy_b) begin
      b_apply <= a_apply;
      b_stack <= (a_region == REGION_STACK);
      b_pages <= a_apply ? pages : '0;
      b_base  <= a_base;
      b_rnd   <= a_rnd;
    end
  end

  // scale to bytes and apply
  logic [31:0] offset;

  assign offset = 32'(b_pages) * 32'(PageBytes);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (rdy_o) begin
      o_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && rdy_o) begin
      o_address <= b_stack ? (b_base - offset) : (b_base + offset);
      o_offset  <= offset[27:0];
      o_rnd     <= b_rnd;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {4'b0, o_rnd, o_offset, o_address};

  // a seed load never carries a random value or an offset
  assert property (@(posedge clk) disable iff (rst)
    in_fire && (in_op == OP_SEED) |=> !a_apply && (a_rnd == '0) && (a_base == '0))
    else $error("seed load left a nonzero payload");

  // a reduced page count is always below the largest limit
  assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (b_pages != PAGES_MMAP))
    else $error("page count not reduced");

  // no offset without an applied region
  assert property (@(posedge clk) disable iff (rst)
    b_valid && !b_apply |-> (b_pages == '0))
    else $error("offset on a pass-through item");

  // any offset comes from a generator step
  assert property (@(posedge clk) disable iff (rst)
    o_valid && (o_offset != '0) |-> (o_rnd != '0))
    else $error("offset without random value");

endmodule : randomized_region_address

`default_nettype wire
